>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file ncv_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, muted while reset is high.
`define NCV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ncv assertion failed");

// Property sampled on the rising clock edge, checked during reset as well.
`define NCV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ncv assertion failed");

`endif

>>> rtl/ncv_pkg.sv
`timescale 1ns / 1ps
package ncv_pkg;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [1:0] COUNT_MAX = 2'd3;
  localparam logic [1:0] DIGITS_EXPECTED = 2'd2;
  localparam logic [4:0] HEX_RADIX = 5'd16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_FORMAT   = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } char_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] computed_sum;
  } result_t;

  // Digit value of an ASCII hex character; HEX_RADIX when it is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_RADIX;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 5'(c[2:0]) + 5'd9;
    end
    return v;
  endfunction

endpackage

>>> rtl/ncv_stream_if.sv
`timescale 1ns / 1ps
interface ncv_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ncv_in_reg.sv
`timescale 1ns / 1ps
module ncv_in_reg import ncv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ncv_stream_if.sink chars,
  input  logic  consume,
  output logic  item_valid,
  output char_t item
);

  assign chars.ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item <= chars.data;
    end
  end

endmodule

>>> rtl/ncv_core.sv
`timescale 1ns / 1ps
module ncv_core import ncv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  char_t   item,
  output result_t res
);

  logic [7:0] running_xor, running_xor_next;
  logic       star_seen, star_seen_next;
  logic [1:0] chars_after_star, chars_after_star_next;
  logic       high_digit_match, high_digit_match_next;
  logic [4:0] digit;
  logic       low_match;

  assign digit = hex_value(item.data_byte);

  always_comb begin
    running_xor_next      = running_xor;
    star_seen_next        = star_seen;
    chars_after_star_next = chars_after_star;
    high_digit_match_next = high_digit_match;
    low_match             = 1'b0;
    if (!star_seen) begin
      if (item.data_byte == STAR_CHAR) begin
        star_seen_next = 1'b1;
      end else begin
        running_xor_next = running_xor ^ item.data_byte;
      end
    end else begin
      if (chars_after_star == 2'd0) begin
        high_digit_match_next = (digit == {1'b0, running_xor[7:4]});
      end else if (chars_after_star == 2'd1) begin
        low_match = (digit == {1'b0, running_xor[3:0]});
      end
      if (chars_after_star != COUNT_MAX) begin
        chars_after_star_next = chars_after_star + 2'd1;
      end
    end
  end

  always_comb begin
    res.computed_sum = running_xor_next;
    if (!star_seen_next) begin
      res.status = ST_NONE;
    end else if (chars_after_star_next != DIGITS_EXPECTED) begin
      res.status = ST_FORMAT;
    end else if (high_digit_match_next && low_match) begin
      res.status = ST_OK;
    end else begin
      res.status = ST_MISMATCH;
    end
  end

  // Clear the sentence state on reset and after the final byte; otherwise advance it.
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_byte)) begin
      running_xor      <= '0;
      star_seen        <= 1'b0;
      chars_after_star <= '0;
      high_digit_match <= 1'b0;
    end else if (advance) begin
      running_xor      <= running_xor_next;
      star_seen        <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      high_digit_match <= high_digit_match_next;
    end
  end

endmodule

>>> rtl/ncv_out_reg.sv
`timescale 1ns / 1ps
module ncv_out_reg import ncv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  ncv_stream_if.source result,
  output logic    free
);

  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.data <= res;
    end
  end

endmodule

>>> rtl/nmea_checksum_validator_top.sv
`timescale 1ns / 1ps
// NMEA 0183 sentence checksum checker.
// chars: one sentence character per item (data_byte, last_byte), the leading
//   dollar sign already stripped; last_byte marks the final character.
// result: one item per sentence, sent for the final character only:
//   status (ok, mismatch, format error, no checksum) and computed_sum, the XOR
//   of all characters before the first asterisk.
// Path: an accepted character is held in the input register; the final
//   character's result is computed from it and loaded into the result
//   register, which drives result; a full result register holds it back.
// Throughput: one character per cycle when nothing stalls, set by the single XOR
//   and hex-digit compare between the input register and the result register.
// Stall: while a result waits in the result register, characters that are not
//   final still drain through; a final character holds in the input register
//   and chars.ready drops only once that register is also occupied.
// Reset (rst, synchronous): empty both registers and clear the running
//   checksum, the asterisk flag, the digit count and the high-digit match.
module nmea_checksum_validator_top import ncv_pkg::*; (
  input logic clk,
  input logic rst,
  ncv_stream_if.sink   chars,
  ncv_stream_if.source result
);

  logic    item_valid;
  char_t   item;
  logic    consume;
  logic    free;
  logic    load;
  result_t res;

  // Advance a character unless it is final and the result register is full.
  assign consume = item_valid && (!item.last_byte || free);
  assign load    = consume && item.last_byte;

  ncv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  ncv_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (consume),
    .item    (item),
    .res     (res)
  );

  ncv_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .res    (res),
    .result (result),
    .free   (free)
  );

endmodule

>>> rtl/ncv_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ncv_checker import ncv_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       chars_valid,
  input logic       chars_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] status,
  input logic [7:0] computed_sum
);

  property p_result_hold;
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(computed_sum);
  endproperty

  // A stalled result holds.
  `NCV_ASSERT(a_result_hold, clk, rst, p_result_hold)

  // Reset empties the result register.
  `NCV_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

  // Reset empties the input register, so a character is taken right away.
  `NCV_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> chars_ready)

  // Characters stall only while a result waits.
  `NCV_ASSERT(a_stall_cause, clk, rst, chars_valid && !chars_ready |-> result_valid)

endmodule

bind nmea_checksum_validator_top ncv_checker u_ncv_checker (
  .clk          (clk),
  .rst          (rst),
  .chars_valid  (chars.valid),
  .chars_ready  (chars.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.data.status),
  .computed_sum (result.data.computed_sum)
);

>>> dv/nmea_checksum_validator_checker.sv
`timescale 1ns / 1ps
// Watch both channels, fold every accepted character into a shadow copy of
// the sentence state, and compare each result item against the oldest
// expected one.
module nmea_checksum_validator_checker import ncv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    chars_valid,
  input  logic    chars_ready,
  input  char_t   chars_data,
  input  logic    res_valid,
  input  logic    res_ready,
  input  result_t res_data,
  output int      fail_count,
  output int      pending,
  output int      ok_count,
  output int      mismatch_count,
  output int      format_count,
  output int      none_count
);

  logic [7:0] sum_acc;
  logic       star_hit;
  logic [1:0] tail_count;
  logic       hi_ok;
  result_t    sum_expected_q[$];
  int         fails;
  int         n_ok, n_mis, n_fmt, n_none;

  initial begin
    fails = 0;
    n_ok = 0;
    n_mis = 0;
    n_fmt = 0;
    n_none = 0;
    fail_count = 0;
    pending = 0;
    ok_count = 0;
    mismatch_count = 0;
    format_count = 0;
    none_count = 0;
  end

  // Digit value of a hex character in either case; HEX_RADIX otherwise.
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return HEX_RADIX;
  endfunction

  task automatic fold_char(input char_t c);
    logic     lo_ok;
    result_t  r;
    lo_ok = 1'b0;
    if (!star_hit) begin
      if (c.data_byte == STAR_CHAR) star_hit = 1'b1;
      else sum_acc = sum_acc ^ c.data_byte;
    end else begin
      if (tail_count == 2'd0) hi_ok = (digit_val(c.data_byte) == {1'b0, sum_acc[7:4]});
      else if (tail_count == 2'd1) lo_ok = (digit_val(c.data_byte) == {1'b0, sum_acc[3:0]});
      if (tail_count < COUNT_MAX) tail_count = tail_count + 2'd1;
    end
    if (c.last_byte) begin
      if (!star_hit) r.status = ST_NONE;
      else if (tail_count != DIGITS_EXPECTED) r.status = ST_FORMAT;
      else if (hi_ok && lo_ok) r.status = ST_OK;
      else r.status = ST_MISMATCH;
      r.computed_sum = sum_acc;
      sum_expected_q.push_back(r);
      sum_acc = 8'h00;
      star_hit = 1'b0;
      tail_count = 2'd0;
      hi_ok = 1'b0;
    end
  endtask

  task automatic match_result(input result_t got);
    result_t want;
    if (sum_expected_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: unexpected result status %0d sum %h", $realtime, got.status,
                 got.computed_sum);
    end else begin
      want = sum_expected_q.pop_front();
      if (got.status !== want.status || got.computed_sum !== want.computed_sum) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result mismatch: expected status %0d sum %h, got status %0d sum %h",
                   $realtime, want.status, want.computed_sum, got.status, got.computed_sum);
      end
      case (want.status)
        ST_OK:       n_ok++;
        ST_MISMATCH: n_mis++;
        ST_FORMAT:   n_fmt++;
        default:     n_none++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sum_acc = 8'h00;
      star_hit = 1'b0;
      tail_count = 2'd0;
      hi_ok = 1'b0;
      sum_expected_q.delete();
    end else begin
      // Drain first: a result never belongs to a character taken on the same edge.
      if (res_valid && res_ready) match_result(res_data);
      if (chars_valid && chars_ready) fold_char(chars_data);
    end
    fail_count <= fails;
    pending <= sum_expected_q.size();
    ok_count <= n_ok;
    mismatch_count <= n_mis;
    format_count <= n_fmt;
    none_count <= n_none;
  end

endmodule

>>> dv/nmea_checksum_validator_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the sentence checksum checker. The checker module
// beside the block does all prediction and comparison; this top only builds
// sentences, drives them with bursty timing, stalls the result side and
// reports the outcome.
module nmea_checksum_validator_top_test;
  import ncv_pkg::*;

  logic clk;
  logic rst;

  ncv_stream_if #(.payload_t(char_t))   chars_if ();
  ncv_stream_if #(.payload_t(result_t)) res_if ();

  int fail_count, pending;
  int ok_count, mismatch_count, format_count, none_count;

  nmea_checksum_validator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (res_if)
  );

  nmea_checksum_validator_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .chars_valid    (chars_if.valid),
    .chars_ready    (chars_if.ready),
    .chars_data     (chars_if.data),
    .res_valid      (res_if.valid),
    .res_ready      (res_if.ready),
    .res_data       (res_if.data),
    .fail_count     (fail_count),
    .pending        (pending),
    .ok_count       (ok_count),
    .mismatch_count (mismatch_count),
    .format_count   (format_count),
    .none_count     (none_count)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result-side stall pattern: every phase picks a mode, from always ready
  // through a random bit pattern to mostly stalled.
  logic [1:0]  ready_mode = 2'd0;
  logic [31:0] ready_pat = 32'hFFFF_FFFF;
  logic [4:0]  ready_idx = 5'd0;
  int          ready_phase = 0;

  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_pat <= $urandom;
      ready_phase <= $urandom_range(20, 150);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    ready_idx <= ready_idx + 5'd1;
    case (ready_mode)
      2'd0: res_if.ready <= 1'b1;
      2'd1: res_if.ready <= ready_pat[ready_idx];
      2'd2: res_if.ready <= (ready_idx[2:0] == 3'd0);
      default: res_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Sender state: items go out in bursts with gaps between them, except in
  // stretches where gaps are switched off.
  int         burst_left = 0;
  bit         no_gaps = 1'b0;
  int         items_sent = 0;
  logic [7:0] line_q[$];

  task automatic send_char(input logic [7:0] b, input logic fin);
    int    gap_n;
    char_t c;
    if (burst_left == 0) begin
      gap_n = no_gaps ? 0 : $urandom_range(1, 6);
      // Drop valid only when a real gap follows, so it never dips and rises in one step.
      if (gap_n > 0) begin
        chars_if.valid <= 1'b0;
        repeat (gap_n) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    c.data_byte = b;
    c.last_byte = fin;
    chars_if.valid <= 1'b1;
    chars_if.data <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send the buffered sentence, flagging its final byte.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // Any byte but the asterisk, so the body stays in one piece.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == STAR_CHAR) b = ~b;
    return b;
  endfunction

  // Character from the checksum field alphabet: hex digits, stars, junk.
  function automatic logic [7:0] tail_byte();
    case ($urandom_range(0, 3))
      0: return STAR_CHAR;
      1: return hex_char(4'($urandom_range(0, 15)), 1'b1);
      2: return hex_char(4'($urandom_range(0, 15)), 1'b0);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_sentence();
    int         kind, len, pos;
    logic [7:0] sum;
    kind = $urandom_range(0, 99);
    // Mostly short bodies, now and then a long one.
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    sum = 8'h00;
    if (kind < 60) begin
      // Well-formed: body, star, two digits of the true sum, sometimes corrupted.
      for (int i = 0; i < len; i++) begin
        line_q.push_back(body_byte());
        sum = sum ^ line_q[i];
      end
      line_q.push_back(STAR_CHAR);
      line_q.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
      line_q.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 99) < 15) begin
        pos = line_q.size() - 1 - $urandom_range(0, 1);
        line_q[pos] = tail_byte();
      end
    end else if (kind < 70) begin
      // No star at all.
      for (int i = 0; i <= len; i++) line_q.push_back(body_byte());
    end else if (kind < 80) begin
      // Wrong number of characters after the star.
      for (int i = 0; i < len; i++) line_q.push_back(body_byte());
      line_q.push_back(STAR_CHAR);
      pos = $urandom_range(0, 4);
      if (pos == 2) pos = 0;
      for (int i = 0; i < pos; i++) line_q.push_back(tail_byte());
    end else if (kind < 90) begin
      // Exactly two characters after the star, drawn from hex digits, junk and stars.
      for (int i = 0; i < len; i++) line_q.push_back(body_byte());
      line_q.push_back(STAR_CHAR);
      line_q.push_back(tail_byte());
      line_q.push_back(tail_byte());
    end else begin
      // Noise: any bytes, stars included.
      pos = $urandom_range(1, 8);
      for (int i = 0; i < pos; i++) line_q.push_back(8'($urandom_range(0, 255)));
    end
    send_line();
  endtask

  // Hard stop well past the slowest correct run.
  initial begin
    #5_000_000;
    $display("nmea_checksum_validator_top_test: done, errors");
    $finish;
  end

  initial begin
    int spins;
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.data = '0;
    res_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed sentences: correct sum in upper and lower case, extreme bytes
    // with no star, star as the final byte, a second star in the digits,
    // too many digits, and a non-hex digit.
    send_text("A*41");
    send_text("z*7a");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    send_line();
    send_text("B*");
    send_text("C**3");
    send_text("*000");
    send_text("*0g");

    // Random sentences until the item budget is spent.
    while (items_sent < 1050) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      random_sentence();
    end
    chars_if.valid <= 1'b0;

    // Wait for outstanding results, then let the pipeline settle.
    spins = 0;
    while (pending != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);

    $display("sent %0d chars; results: %0d ok, %0d mismatch, %0d format error, %0d no checksum",
             items_sent, ok_count, mismatch_count, format_count, none_count);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("nmea_checksum_validator_top_test: done, clean");
    end else begin
      $display("nmea_checksum_validator_top_test: done, errors");
    end
    $finish;
  end

endmodule
